>>> design/matrix_multiply_assert.svh
// Assertion macros shared by the matrix multiply RTL.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define MM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define MM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mm_pkg.sv
package mm_pkg;
  localparam int unsigned RowsA     = 4;
  localparam int unsigned Inner     = 4;
  localparam int unsigned ColsB     = 4;
  localparam int unsigned DataWidth = 16;
  localparam int unsigned SumWidth  = 34;
  localparam int unsigned IdxWidth  = 2;
  localparam int unsigned ProdWidth = 2 * DataWidth;

  localparam logic [1:0] ReqLoadA   = 2'd0;
  localparam logic [1:0] ReqLoadB   = 2'd1;
  localparam logic [1:0] ReqCompute = 2'd2;

  // Step control record for the chain of cells: start flag and inner index.
  typedef struct packed {
    logic          start;
    logic [IdxWidth-1:0] kk;
  } mm_step_t;
endpackage

>>> design/mm_cell.sv
// One multiply-accumulate cell: registers a product, then adds it to the
// partial sum from its left neighbor and hands the sum on.
module mm_cell import mm_pkg::*; (
  input  logic                        clk_i,
  input  logic signed [DataWidth-1:0] a_i,
  input  logic signed [DataWidth-1:0] b_i,
  input  logic signed [SumWidth-1:0]  sum_i,
  output logic signed [SumWidth-1:0]  sum_o
);
  logic signed [ProdWidth-1:0] prod_q;
  logic signed [SumWidth-1:0]  sum_in_q;
  logic signed [SumWidth-1:0]  sum_q;

  // stage 1: multiply; stage 2: accumulate
  always_ff @(posedge clk_i) begin
    prod_q   <= a_i * b_i;
    sum_in_q <= sum_i;
    sum_q    <= sum_in_q + SumWidth'(prod_q);
  end

  assign sum_o = sum_q;
endmodule

>>> design/matrix_multiply.sv
// Integer matrix multiply, 4x4 by 4x4, signed 16-bit elements.
// Input channel (req_*): req_type 0 writes an A element at row/col, 1 writes
// a B element, 2 starts a product run; code 3 does nothing, and the 2-bit
// indices cannot go out of range. Each accepted load writes its element.
// Output channel (res_*): a compute emits the 16 product elements in
// row-major order with full-width 34-bit sums; last marks the final beat.
// A compute beat starts a run that issues one product element per cycle while
// FIFO space remains, into a chain of four multiply-accumulate cells (one per
// inner index, each with a multiply and an accumulate register); the results
// leave one per cycle when the receiver never stalls. The input is not ready
// while a run is in flight: the next beat is taken only after all products
// have been issued, have left the chain and have drained from the FIFO.
// A result FIFO of 16 beats buffers the run; issue pauses when it could fill,
// so a stalled receiver loses nothing and only holds the input off longer.
// Reset clears control state; matrix contents are undefined until loaded.
module matrix_multiply import mm_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [IdxWidth-1:0]         row_index_i,
  input  logic [IdxWidth-1:0]         col_index_i,
  input  logic signed [DataWidth-1:0] element_value_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output logic [IdxWidth-1:0]         out_row_o,
  output logic [IdxWidth-1:0]         out_col_o,
  output logic signed [SumWidth-1:0]  product_sum_o,
  output logic                        last_o
);
  `include "matrix_multiply_assert.svh"

  localparam int unsigned Lat  = 2 * Inner;
  localparam int unsigned NOut = RowsA * ColsB;
  localparam int unsigned FDep = 16;

  logic signed [DataWidth-1:0] a_q [RowsA][Inner];
  logic signed [DataWidth-1:0] b_q [Inner][ColsB];

  logic       busy_q;
  logic [1:0] i_q, j_q;
  logic       issue;
  logic       done_issue_q;

  // tag line runs alongside the cell chain
  logic [Lat:0] vld_q;
  logic [1:0]   ti_q [Lat+1];
  logic [1:0]   tj_q [Lat+1];

  // FIFO
  logic [IdxWidth+IdxWidth+SumWidth:0] fifo_q [FDep];
  logic [3:0] wp_q, rp_q;
  logic [4:0] cnt_q;
  logic [4:0] inflight;
  logic       push, pop;

  logic req_acc;
  assign req_ready_o = !busy_q;
  assign req_acc     = req_valid_i && req_ready_o;

  // element stores
  always_ff @(posedge clk_i) begin
    if (req_acc && req_type_i == ReqLoadA) a_q[row_index_i][col_index_i] <= element_value_i;
    if (req_acc && req_type_i == ReqLoadB) b_q[row_index_i][col_index_i] <= element_value_i;
  end

  // issue one element per cycle while FIFO space remains
  always_comb begin
    inflight = 5'(cnt_q);
    for (int n = 0; n <= Lat; n++) inflight = inflight + 5'(vld_q[n]);
  end
  assign issue = busy_q && !done_issue_q && (inflight < 5'(FDep));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_issue_q <= 1'b0; i_q <= '0; j_q <= '0;
    end else begin
      if (req_acc && req_type_i == ReqCompute) begin
        busy_q <= 1'b1; done_issue_q <= 1'b0; i_q <= '0; j_q <= '0;
      end else if (issue) begin
        if (j_q == 2'(ColsB - 1)) begin
          j_q <= '0;
          if (i_q == 2'(RowsA - 1)) done_issue_q <= 1'b1;
          else i_q <= i_q + 2'd1;
        end else j_q <= j_q + 2'd1;
      end else if (done_issue_q && vld_q == '0 && cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // operand skew: each cell takes its operands from a later register of its skew line
  logic signed [DataWidth-1:0] ska_q [Inner][Lat+1];
  logic signed [DataWidth-1:0] skb_q [Inner][Lat+1];
  logic signed [SumWidth-1:0]  chain [Inner+1];
  assign chain[0] = '0;

  for (genvar k = 0; k < Inner; k++) begin : g_cell
    always_ff @(posedge clk_i) begin
      ska_q[k][0] <= a_q[i_q][k];
      skb_q[k][0] <= b_q[k][j_q];
      for (int s = 1; s <= Lat; s++) begin
        ska_q[k][s] <= ska_q[k][s-1];
        skb_q[k][s] <= skb_q[k][s-1];
      end
    end
    mm_cell u_cell (
      .clk_i (clk_i),
      .a_i   (ska_q[k][2*k]),
      .b_i   (skb_q[k][2*k]),
      .sum_i (chain[k]),
      .sum_o (chain[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[Lat-1:0], issue};
  end
  always_ff @(posedge clk_i) begin
    ti_q[0] <= i_q; tj_q[0] <= j_q;
    for (int s = 1; s <= Lat; s++) begin
      ti_q[s] <= ti_q[s-1]; tj_q[s] <= tj_q[s-1];
    end
  end

  // results leave the chain when the issue flag reaches the last stage of the valid line
  logic lst;
  assign push = vld_q[Lat];
  assign lst  = (ti_q[Lat] == 2'(RowsA - 1)) && (tj_q[Lat] == 2'(ColsB - 1));
  assign pop  = res_valid_o && res_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= {ti_q[Lat], tj_q[Lat], chain[Inner], lst};
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 4'd1;
      if (pop)  rp_q <= rp_q + 4'd1;
      cnt_q <= cnt_q + 5'(push) - 5'(pop);
    end
  end

  assign res_valid_o = cnt_q != '0;
  assign {out_row_o, out_col_o, product_sum_o, last_o} = fifo_q[rp_q];

  `MM_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, push, cnt_q < 5'(FDep) || pop,
    "result FIFO overflow")
  `MM_ASSERT_IMPL(a_idle_empty, clk_i, rst_ni, !busy_q, cnt_q == '0 && vld_q == '0,
    "results pending while idle")
  `MM_ASSERT_NEXT(a_issue_busy, clk_i, rst_ni, issue, busy_q,
    "issue dropped busy")
endmodule

>>> sim/tb_matrix_multiply.sv
`timescale 1ns / 100ps

module tb_matrix_multiply;
  import mm_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [15:0] value;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [33:0] sum;
    logic               last;
  } prod_beat_t;

  // Unused request code 3, sent as a beat that the DUT must ignore
  localparam logic [1:0] DrainMark = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  logic [1:0] req_type_i = '0;
  logic [1:0] row_index_i = '0;
  logic [1:0] col_index_i = '0;
  logic signed [15:0] element_value_i = '0;
  logic res_valid_o;
  logic res_ready_i = 1'b0;
  logic [1:0] out_row_o;
  logic [1:0] out_col_o;
  logic signed [33:0] product_sum_o;
  logic last_o;

  matrix_multiply dut (.*);

  always #4 clk_i = ~clk_i;

  // Stimulus queue; each entry carries a drain flag
  req_beat_t  pending_reqs[$];
  bit         drain_flags[$];
  prod_beat_t expected_products[$];
  int unsigned fail_count = 0;
  bit quiet_mode = 1'b0;
  bit stim_done = 1'b0;

  // Predictor copy of the two matrices
  logic signed [15:0] mat_a[RowsA][Inner];
  logic signed [15:0] mat_b[Inner][ColsB];

  task automatic predict_request(input req_beat_t r);
    logic signed [33:0] acc;
    prod_beat_t p;
    case (r.kind)
      ReqLoadA: mat_a[r.row][r.col] = r.value;
      ReqLoadB: mat_b[r.row][r.col] = r.value;
      ReqCompute: begin
        for (int i = 0; i < RowsA; i++) begin
          for (int j = 0; j < ColsB; j++) begin
            acc = '0;
            for (int k = 0; k < Inner; k++)
              acc += 34'(mat_a[i][k] * mat_b[k][j]);
            p.row = i[1:0];
            p.col = j[1:0];
            p.sum = acc;
            p.last = (i == RowsA - 1) && (j == ColsB - 1);
            expected_products.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic req_beat_t mk(input logic [1:0] kind, input int row, input int col,
                                   input logic signed [15:0] value);
    req_beat_t r;
    r.kind = kind;
    r.row = row[1:0];
    r.col = col[1:0];
    r.value = value;
    return r;
  endfunction

  task automatic add_req(input req_beat_t r, input bit drain = 1'b0);
    pending_reqs.push_back(r);
    drain_flags.push_back(drain);
  endtask

  task automatic fill_both(input int mode);
    logic signed [15:0] v;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        for (int m = 0; m < 2; m++) begin
          case (mode)
            0: v = 16'sh8000;
            1: v = 16'sh7fff;
            default: v = 16'($urandom);
          endcase
          if (mode == 2 && $urandom_range(0, 3) == 0)
            v = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7fff;
          add_req(mk(m ? ReqLoadB : ReqLoadA, r, c, v));
        end
      end
    end
  endtask

  // Sender: pops pending beats, random idle bursts, drain pause on request
  int send_gap = 0;
  bit draining = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid_i && req_ready_o) begin
        predict_request({req_type_i, row_index_i, col_index_i, element_value_i});
        void'(pending_reqs.pop_front());
        void'(drain_flags.pop_front());
      end
      if (!(req_valid_i && !req_ready_o)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_valid_i <= 1'b0;
        end else if ((req_valid_i && req_ready_o ? pending_reqs.size() > 1 - 1 : 1) &&
                     pending_reqs.size() > ((req_valid_i && req_ready_o) ? 0 : 0) &&
                     !(drain_flags[0] && expected_products.size() != 0) &&
                     !(req_valid_i && req_ready_o && drain_flags.size() == 0)) begin
          if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            send_gap <= $urandom_range(1, 9) - 1;
            req_valid_i <= 1'b0;
          end else if (drain_flags.size() != 0) begin
            req_valid_i <= 1'b1;
            {req_type_i, row_index_i, col_index_i, element_value_i} <= pending_reqs[0];
          end else begin
            req_valid_i <= 1'b0;
          end
        end else begin
          req_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted product beat against the oldest expectation; random ready gaps
  int recv_gap = 0;
  prod_beat_t want;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o && res_ready_i) begin
        if (expected_products.size() == 0) begin
          $error("unexpected product beat row=%0d col=%0d", out_row_o, out_col_o);
          fail_count++;
        end else begin
          want = expected_products.pop_front();
          if (out_row_o !== want.row) begin
            $error("out_row expected %0d actual %0d", want.row, out_row_o);
            fail_count++;
          end
          if (out_col_o !== want.col) begin
            $error("out_col expected %0d actual %0d", want.col, out_col_o);
            fail_count++;
          end
          if (product_sum_o !== want.sum) begin
            $error("product_sum expected %0d actual %0d", want.sum, product_sum_o);
            fail_count++;
          end
          if (last_o !== want.last) begin
            $error("last expected %0d actual %0d", want.last, last_o);
            fail_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        res_ready_i <= 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(1, 9) - 1;
        res_ready_i <= 1'b0;
      end else begin
        res_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus and end of run
  initial begin
    logic [1:0] kind;
    // directed: extremes, out-of-range-free indexes, unused code, computes
    fill_both(0);
    add_req(mk(ReqCompute, 0, 0, 16'sd0));
    add_req(mk(DrainMark, 3, 3, 16'sh7fff));
    add_req(mk(ReqLoadA, 3, 0, 16'sh7fff), 1'b1);
    add_req(mk(ReqCompute, 3, 3, 16'sh8000));
    fill_both(1);
    add_req(mk(ReqCompute, 0, 0, 16'sd0));
    // random: mostly single loads and computes
    for (int n = 0; n < 40; n++) begin
      kind = ($urandom_range(0, 9) < 2) ? ReqCompute :
             ($urandom_range(0, 19) == 0) ? DrainMark : 2'($urandom_range(0, 1));
      add_req(mk(kind, $urandom_range(0, 3), $urandom_range(0, 3), 16'($urandom)),
              $urandom_range(0, 29) == 0);
    end
    add_req(mk(ReqCompute, 0, 0, 16'sd0));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() < 40);
    quiet_mode = 1'b1;
    wait (pending_reqs.size() == 0);
    wait (expected_products.size() == 0);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && expected_products.size() == 0)
      $display("tb_matrix_multiply OK");
    else
      $display("tb_matrix_multiply NOT OK");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_matrix_multiply NOT OK");
    $finish;
  end
endmodule
